[design/dsobel_pkg.sv]
`default_nettype none

package dsobel_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int PIXEL_BITS_DEF = 8;

	localparam int PIX_IN_W    = 8;
	localparam int COORD_W     = 8;
	localparam int LEVEL_W     = 8;
	localparam int SIZE_W      = 9;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEVEL    = 2'd2;

	localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RST  = 9'd256;
	localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RST = 9'd256;
	localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST    = 8'd255;

	typedef struct packed {
		logic               has_res;
		logic               frame_end;
		logic [COORD_W-1:0] center_row;
		logic [COORD_W-1:0] center_col;
	} scan_info_t;

endpackage

`default_nettype wire

[design/dsobel_if.sv]
`default_nettype none

interface dsobel_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface dsobel_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] filtered_value;
	logic [7:0] center_row;
	logic [7:0] center_col;
	logic       frame_end;

	modport source (output valid, output filtered_value, output center_row,
		output center_col, output frame_end, input ready);
	modport sink (input valid, input filtered_value, input center_row,
		input center_col, input frame_end, output ready);
endinterface

`default_nettype wire

[design/dsobel_ram.sv]
`default_nettype none

module dsobel_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       wr_en,
	input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
	input  wire  [WIDTH-1:0]          wr_data,
	input  wire                       rd_en,
	input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [WIDTH-1:0]          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

[design/dsobel_scan.sv]
`default_nettype none

module dsobel_scan #(
	parameter int MAX_WIDTH  = dsobel_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dsobel_pkg::MAX_HEIGHT_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 step,
	input  wire  [dsobel_pkg::SIZE_W-1:0]       frame_width,
	input  wire  [dsobel_pkg::SIZE_W-1:0]       frame_height,
	output logic [$clog2(MAX_WIDTH)-1:0]        addr,
	output dsobel_pkg::scan_info_t              info
);
	import dsobel_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WSW = ($clog2(MAX_WIDTH + 1) > SIZE_W) ? $clog2(MAX_WIDTH + 1) : SIZE_W;
	localparam int HSW = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ? $clog2(MAX_HEIGHT + 1) : SIZE_W;

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [WSW-1:0] width_raw, width_eff;
	logic [HSW-1:0] height_raw, height_eff;
	logic           col_last, row_last;
	logic [CW-1:0]  col_m1;
	logic [RW-1:0]  row_m1;

	// size registers saturated into 3..max
	always_comb begin
		width_raw  = WSW'(frame_width);
		height_raw = HSW'(frame_height);
		if (width_raw < WSW'(3)) begin
			width_eff = WSW'(3);
		end else if (width_raw > WSW'(MAX_WIDTH)) begin
			width_eff = WSW'(MAX_WIDTH);
		end else begin
			width_eff = width_raw;
		end
		if (height_raw < HSW'(3)) begin
			height_eff = HSW'(3);
		end else if (height_raw > HSW'(MAX_HEIGHT)) begin
			height_eff = HSW'(MAX_HEIGHT);
		end else begin
			height_eff = height_raw;
		end
	end

	assign col_last = (WSW'(col_q) + WSW'(1)) >= width_eff;
	assign row_last = (HSW'(row_q) + HSW'(1)) >= height_eff;
	assign col_m1   = col_q - CW'(1);
	assign row_m1   = row_q - RW'(1);

	assign addr            = col_q;
	assign info.has_res    = (col_q >= CW'(2)) && (row_q >= RW'(2));
	assign info.frame_end  = col_last && row_last;
	assign info.center_row = COORD_W'(row_m1);
	assign info.center_col = COORD_W'(col_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[design/dsobel_win.sv]
`default_nettype none

module dsobel_win #(
	parameter int PIXEL_BITS = dsobel_pkg::PIXEL_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              step,
	input  wire  [PIXEL_BITS-1:0]            pix,
	input  wire  [PIXEL_BITS-1:0]            above1,
	input  wire  [PIXEL_BITS-1:0]            above2,
	input  dsobel_pkg::scan_info_t           info,
	input  wire  [dsobel_pkg::LEVEL_W-1:0]   max_level,
	output logic                             out_stall,
	dsobel_res_if.source                     results
);
	import dsobel_pkg::*;

	localparam int SUMW = ((PIXEL_BITS > LEVEL_W) ? PIXEL_BITS : LEVEL_W) + 3;

	// window columns kept as far as the kernel needs them
	logic [PIXEL_BITS-1:0] top2_q;
	logic [PIXEL_BITS-1:0] mid1_q, mid2_q;
	logic [PIXEL_BITS-1:0] bot1_q, bot2_q;

	logic [SUMW-1:0]        pos_sum, neg_sum, level_ext, clamped;
	logic signed [SUMW-1:0] diff;

	logic               valid_q;
	logic [LEVEL_W-1:0] value_q;
	logic [COORD_W-1:0] row_q, col_q;
	logic               end_q;

	// kernel applied to the window ending at this pixel's column, before its shift
	always_comb begin
		pos_sum   = SUMW'(mid1_q) + SUMW'({bot1_q, 1'b0}) + SUMW'(bot2_q);
		neg_sum   = SUMW'(top2_q) + SUMW'({above2, 1'b0}) + SUMW'(above1);
		diff      = $signed(pos_sum) - $signed(neg_sum);
		level_ext = SUMW'(max_level);
		if (diff[SUMW-1]) begin
			clamped = '0;
		end else if (unsigned'(diff) > level_ext) begin
			clamped = level_ext;
		end else begin
			clamped = unsigned'(diff);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			top2_q <= above2;
			mid1_q <= mid2_q;
			mid2_q <= above1;
			bot1_q <= bot2_q;
			bot2_q <= pix;
		end
		if (step && info.has_res) begin
			value_q <= LEVEL_W'(clamped);
			row_q   <= info.center_row;
			col_q   <= info.center_col;
			end_q   <= info.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step && info.has_res) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_stall              = valid_q && !results.ready;
	assign results.valid          = valid_q;
	assign results.filtered_value = value_q;
	assign results.center_row     = row_q;
	assign results.center_col     = col_q;
	assign results.frame_end      = end_q;

endmodule

`default_nettype wire

[design/diagonal_sobel_3x3_filter.sv]
// Diagonal Sobel 3x3 edge filter on a raster pixel stream.
// pixels: one grayscale pixel per request, raster order, valid/ready.
// results: one request per interior window centre carrying the clamped
//   kernel response, the centre's row and column, and frame_end on the last
//   interior centre of a frame. Border pixels produce no result.
// cfg port: cfg_write with cfg_index 0 = frame_width, 1 = frame_height,
//   2 = max_level; write only while the filter holds no pixel in flight.
// Throughput: one pixel per cycle, sustained unless the output stalls. Each
//   pixel reads its column of the two-row line store (one 2*PIXEL_BITS word)
//   on acceptance and writes it back as it leaves the input stage, so the
//   line store RAM sets that rate.
// A pixel's result is registered in the input stage, then in the output register.
// Reset clears the row/column counters, empties the pipeline and loads the
//   size and level registers with 256, 256 and 255. The line store is not
//   cleared; rows are refilled before any window depends on them.
// A stalled result holds the output register; border pixels keep passing
//   through the input stage, and once a pixel that yields a result sits
//   there, ready drops until the stalled result leaves.
`default_nettype none

module diagonal_sobel_3x3_filter #(
	parameter int MAX_WIDTH  = dsobel_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dsobel_pkg::MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = dsobel_pkg::PIXEL_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_write,
	input  wire  [dsobel_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire  [dsobel_pkg::CFG_DATA_W-1:0]    cfg_data,
	dsobel_pix_if.sink                           pixels,
	dsobel_res_if.source                         results
);
	import dsobel_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int PEXTW = (PIXEL_BITS > PIX_IN_W) ? PIXEL_BITS : PIX_IN_W;

	logic [SIZE_W-1:0]  frame_width_q, frame_height_q;
	logic [LEVEL_W-1:0] max_level_q;

	logic                  accept, s1_adv, out_stall;
	logic [PEXTW-1:0]      pix_ext;
	logic [CW-1:0]         scan_addr;
	scan_info_t            scan_info;
	logic [2*PIXEL_BITS-1:0] ram_rd;

	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [CW-1:0]         addr_s1;
	scan_info_t            info_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			max_level_q    <= MAX_LEVEL_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_MAX_LEVEL:    max_level_q    <= LEVEL_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// input stage moves on unless it holds a result that cannot leave
	assign s1_adv       = valid_s1 && (!info_s1.has_res || !out_stall);
	assign pixels.ready = !valid_s1 || s1_adv;
	assign accept       = pixels.valid && pixels.ready;
	assign pix_ext      = PEXTW'(pixels.pixel_value);

	dsobel_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (accept),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.addr         (scan_addr),
		.info         (scan_info)
	);

	// word holds row r-2 in the upper half and row r-1 in the lower half
	dsobel_ram #(
		.WIDTH (2 * PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (addr_s1),
		.wr_data ({ram_rd[PIXEL_BITS-1:0], pix_s1}),
		.rd_en   (accept),
		.rd_addr (scan_addr),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix_ext[PIXEL_BITS-1:0];
			addr_s1 <= scan_addr;
			info_s1 <= scan_info;
		end
	end

	dsobel_win #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_adv),
		.pix       (pix_s1),
		.above1    (ram_rd[PIXEL_BITS-1:0]),
		.above2    (ram_rd[2*PIXEL_BITS-1:PIXEL_BITS]),
		.info      (info_s1),
		.max_level (max_level_q),
		.out_stall (out_stall),
		.results   (results)
	);

`ifndef SYNTH
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && info_s1.has_res) |=> results.valid)
		else $error("result from input stage not presented");

	a_frame_end_interior: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && info_s1.frame_end) |-> info_s1.has_res)
		else $error("frame end flagged on a border position");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted pixel lost from input stage");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && info_s1.has_res) |-> !out_stall)
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
